/* sv/mst_pkg.sv */
`timescale 1ns / 1ps

package mst_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int PER_W       = 15;
  localparam int REM_W       = 16;

  localparam logic [REM_W-1:0] REM_MIN = 16'h8000;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_START    = 2'd1,
    REQ_STOP     = 2'd2,
    REQ_DISPATCH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_STOP   = 2'd1,
    KIND_EXPIRY = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_ZERO_PERIOD = 2'd1,
    STAT_FULL        = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic rem_wr;
    logic per_wr;
  } ram_ctl_t;

endpackage

/* sv/mst_slot_ram.sv */
`timescale 1ns / 1ps

module mst_slot_ram #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF,
  parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                        clk,
  input  mst_pkg::ram_ctl_t           ctl,
  input  logic [IW-1:0]               rd_addr,
  input  logic [IW-1:0]               wr_addr,
  input  logic [mst_pkg::REM_W-1:0]   rem_wdata,
  input  logic [mst_pkg::PER_W-1:0]   per_wdata,
  output logic [mst_pkg::REM_W-1:0]   rem_q,
  output logic [mst_pkg::PER_W-1:0]   per_q
);

  logic [mst_pkg::REM_W-1:0] rem_mem [SLOTS];
  logic [mst_pkg::PER_W-1:0] per_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.rem_wr) begin
      rem_mem[wr_addr] <= rem_wdata;
    end
    if (ctl.per_wr) begin
      per_mem[wr_addr] <= per_wdata;
    end
    if (ctl.rd_en) begin
      rem_q <= rem_mem[rd_addr];
      per_q <= per_mem[rd_addr];
    end
  end

endmodule

/* sv/multi_slot_software_timer.sv */
`timescale 1ns / 1ps

// Bank of SLOTS software timers driven by tick, start, stop and dispatch words.
// A tick runs through the accept, one priming read, then a scan of one slot per
// cycle through a single shared 17-bit adder and a slot memory with one read and
// one write port. A dispatch adds a reply state after its scan. Start walks the
// active bits to the lowest free slot; stop and a start with zero period go from
// the accept straight to the reply state. A dispatch pauses its walk while an
// earlier expiry word still waits at the output, and every final reply waits
// until the output is free. The input is not ready while a word is being worked
// on. Slot memory needs no clearing after reset, because a slot's contents are
// only used while that slot is active.

module multi_slot_software_timer #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // slot[2:0], period[17:3], periodic[18], zeros
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // status[1:0], slot_out[4:2], zeros
  output logic [1:0]  m_tuser,  // resp_kind[1:0]
  output logic        m_tlast
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [6:0] SLOTS7 = 7'(SLOTS);

  mst_pkg::state_t state, state_next;

  mst_pkg::req_t                op;
  logic [mst_pkg::PER_W-1:0]    period_in;
  logic                         periodic_in;

  logic [SLOTS-1:0]             active;
  logic [SLOTS-1:0]             periodic;
  logic [IW-1:0]                idx;
  logic [IW-1:0]                idx_next;
  logic [mst_pkg::CNT_W-1:0]    cnt;
  logic [mst_pkg::CNT_W-1:0]    cnt_inc;
  logic                         pend_valid;
  logic [IW-1:0]                pend_slot;

  mst_pkg::kind_t               rep_kind, rep_kind_next;
  mst_pkg::status_t             rep_status, rep_status_next;
  logic [2:0]                   rep_slot, rep_slot_next;
  logic                         rep_load;

  mst_pkg::ram_ctl_t            ram_ctl;
  logic [IW-1:0]                rd_addr;
  logic [mst_pkg::REM_W-1:0]    rem_wdata;
  logic [mst_pkg::REM_W-1:0]    rem_q;
  logic [mst_pkg::PER_W-1:0]    per_q;

  logic [mst_pkg::REM_W:0]      sum;
  logic [mst_pkg::REM_W:0]      operand;
  logic                         s_acc;
  logic                         out_free;
  logic                         cur_active;
  logic                         cur_periodic;
  logic                         expired;
  logic                         scan_last;
  logic                         adv;
  logic                         take;
  logic                         push;
  logic                         claim;
  logic                         free_cur;
  logic                         end_disp;
  logic [IW+2:0]                idx_ext;
  logic [IW+2:0]                pend_ext;

  assign s_acc        = s_tvalid && s_tready;
  assign s_tready     = (state == mst_pkg::ST_IDLE);
  assign out_free     = !m_tvalid || m_tready;
  assign cur_active   = active[idx];
  assign cur_periodic = periodic[idx];
  assign expired      = cur_active && (rem_q[mst_pkg::REM_W-1] || (rem_q == '0));
  assign scan_last    = (idx == LAST_IDX);
  assign idx_next     = scan_last ? '0 : idx + IW'(1);
  assign cnt_inc      = cnt + mst_pkg::CNT_W'(1);
  assign idx_ext      = {3'b000, idx};
  assign pend_ext     = {3'b000, pend_slot};

  // Shared adder: decrement on tick, period reload on dispatch.
  assign operand = (op == mst_pkg::REQ_TICK) ? '1 : {2'b00, per_q};
  assign sum     = {rem_q[mst_pkg::REM_W-1], rem_q} + operand;

  assign rd_addr   = (state == mst_pkg::ST_PRIME) ? '0 : idx_next;
  assign rem_wdata = claim ? {1'b0, period_in} : sum[mst_pkg::REM_W-1:0];
  assign push      = take && pend_valid;

  always_comb begin
    adv             = 1'b0;
    take            = 1'b0;
    claim           = 1'b0;
    free_cur        = 1'b0;
    end_disp        = 1'b0;
    rep_load        = 1'b0;
    rep_kind_next   = mst_pkg::KIND_NONE;
    rep_status_next = mst_pkg::STAT_OK;
    rep_slot_next   = 3'b000;
    ram_ctl         = '0;
    case (state)
      mst_pkg::ST_IDLE: begin
        if (s_acc && (s_tuser == mst_pkg::REQ_START) && (s_tdata[17:3] == '0)) begin
          rep_load        = 1'b1;
          rep_kind_next   = mst_pkg::KIND_START;
          rep_status_next = mst_pkg::STAT_ZERO_PERIOD;
        end else if (s_acc && (s_tuser == mst_pkg::REQ_STOP)) begin
          rep_load      = 1'b1;
          rep_kind_next = mst_pkg::KIND_STOP;
          rep_slot_next = s_tdata[2:0];
        end
      end
      mst_pkg::ST_PRIME: begin
        ram_ctl.rd_en = 1'b1;
      end
      mst_pkg::ST_SCAN: begin
        case (op)
          mst_pkg::REQ_TICK: begin
            adv            = 1'b1;
            ram_ctl.rem_wr = cur_active && (rem_q != mst_pkg::REM_MIN);
          end
          mst_pkg::REQ_START: begin
            if (!cur_active) begin
              claim          = 1'b1;
              ram_ctl.rem_wr = 1'b1;
              ram_ctl.per_wr = 1'b1;
              rep_load       = 1'b1;
              rep_kind_next  = mst_pkg::KIND_START;
              rep_slot_next  = idx_ext[2:0];
            end else begin
              adv = 1'b1;
              if (scan_last) begin
                rep_load        = 1'b1;
                rep_kind_next   = mst_pkg::KIND_START;
                rep_status_next = mst_pkg::STAT_FULL;
              end
            end
          end
          mst_pkg::REQ_DISPATCH: begin
            if (expired) begin
              take           = !(pend_valid && !out_free);
              adv            = take;
              ram_ctl.rem_wr = take && cur_periodic;
              free_cur       = take && !cur_periodic;
              end_disp       = take && (scan_last ||
                               (cnt_inc == mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS)));
            end else begin
              adv      = 1'b1;
              end_disp = scan_last;
            end
            if (end_disp) begin
              rep_load = 1'b1;
              if (expired) begin
                rep_kind_next = mst_pkg::KIND_EXPIRY;
                rep_slot_next = idx_ext[2:0];
              end else if (pend_valid) begin
                rep_kind_next = mst_pkg::KIND_EXPIRY;
                rep_slot_next = pend_ext[2:0];
              end
            end
          end
          default: begin
          end
        endcase
        ram_ctl.rd_en = adv;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      mst_pkg::ST_IDLE: begin
        if (s_acc) begin
          state_next = rep_load ? mst_pkg::ST_REPLY : mst_pkg::ST_PRIME;
        end
      end
      mst_pkg::ST_PRIME: begin
        state_next = mst_pkg::ST_SCAN;
      end
      mst_pkg::ST_SCAN: begin
        if (op == mst_pkg::REQ_TICK) begin
          if (scan_last) begin
            state_next = mst_pkg::ST_IDLE;
          end
        end else if (rep_load) begin
          state_next = mst_pkg::ST_REPLY;
        end
      end
      mst_pkg::ST_REPLY: begin
        if (out_free) begin
          state_next = mst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mst_pkg::ST_IDLE;
      m_tvalid   <= 1'b0;
      active     <= '0;
      periodic   <= '0;
      pend_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (s_acc) begin
        op          <= mst_pkg::req_t'(s_tuser);
        period_in   <= s_tdata[17:3];
        periodic_in <= s_tdata[18];
        if ((s_tuser == mst_pkg::REQ_STOP) && ({4'b0000, s_tdata[2:0]} < SLOTS7)) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (7'(i) == {4'b0000, s_tdata[2:0]}) begin
              active[i]   <= 1'b0;
              periodic[i] <= 1'b0;
            end
          end
        end
      end
      if (state == mst_pkg::ST_PRIME) begin
        idx        <= '0;
        cnt        <= '0;
        pend_valid <= 1'b0;
      end
      if (adv) begin
        idx <= idx_next;
      end
      if (claim) begin
        active[idx]   <= 1'b1;
        periodic[idx] <= periodic_in;
      end
      if (free_cur) begin
        active[idx]   <= 1'b0;
        periodic[idx] <= 1'b0;
      end
      if (take) begin
        pend_valid <= 1'b1;
        pend_slot  <= idx;
        cnt        <= cnt_inc;
      end
      if (rep_load) begin
        rep_kind   <= rep_kind_next;
        rep_status <= rep_status_next;
        rep_slot   <= rep_slot_next;
      end
      if (push) begin
        m_tvalid <= 1'b1;
        m_tuser  <= mst_pkg::KIND_EXPIRY;
        m_tdata  <= {3'b000, pend_ext[2:0], mst_pkg::STAT_OK};
        m_tlast  <= 1'b0;
      end else if ((state == mst_pkg::ST_REPLY) && out_free) begin
        m_tvalid <= 1'b1;
        m_tuser  <= rep_kind;
        m_tdata  <= {3'b000, rep_slot, rep_status};
        m_tlast  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  mst_slot_ram #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_slot_ram (
    .clk       (clk),
    .ctl       (ram_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (idx),
    .rem_wdata (rem_wdata),
    .per_wdata (period_in),
    .rem_q     (rem_q),
    .per_q     (per_q)
  );

  a_tick_saturates: assert property (@(posedge clk) disable iff (rst)
    (state == mst_pkg::ST_SCAN && op == mst_pkg::REQ_TICK && ram_ctl.rem_wr)
      |-> (rem_q != mst_pkg::REM_MIN))
    else $error("tick decremented a saturated count");

  a_pend_only_dispatch: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && state == mst_pkg::ST_SCAN) |-> (op == mst_pkg::REQ_DISPATCH))
    else $error("pending expiry outside a dispatch");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (rst)
    (cnt <= mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS)))
    else $error("expiry count beyond limit");

  a_claim_sets_active: assert property (@(posedge clk) disable iff (rst)
    claim |=> active[$past(idx)])
    else $error("claimed slot not active");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("expiry pushed over a held word");

endmodule

/* sim/multi_slot_software_timer_test.sv */
`timescale 1ns / 1ps

module multi_slot_software_timer_test;

  localparam int SLOTS           = mst_pkg::SLOTS_DEF;
  localparam int DRAIN_CYCLES    = 2 * SLOTS + 8;
  localparam int CYCLE_LIMIT     = 200_000;
  localparam int RANDOM_WORDS    = 310;
  localparam int OVERSHOOT_TICKS = 40;

  typedef struct packed {
    mst_pkg::kind_t   kind;
    mst_pkg::status_t status;
    logic [2:0]       slot;
    logic             last;
  } timer_reply_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // slot[2:0], period[17:3], periodic[18], zeros
  logic [1:0]  s_tuser;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // status[1:0], slot_out[4:2], zeros
  logic [1:0]  m_tuser;   // resp_kind[1:0]
  logic        m_tlast;

  logic                             tmr_active   [SLOTS];
  logic                             tmr_periodic [SLOTS];
  logic [mst_pkg::PER_W-1:0]        tmr_period   [SLOTS];
  logic signed [mst_pkg::REM_W-1:0] tmr_remaining[SLOTS];

  timer_reply_t expected_replies[$];

  int  error_count;
  int  cycle_count;
  int  words_sent;
  int  ticks_sent;
  int  replies_checked;
  int  expiries_seen;
  int  burst_left;
  bit  gapless;
  bit  hold_request;
  int  hold_left;
  int  stall_mode;
  int  mode_left;

  multi_slot_software_timer #(.SLOTS(SLOTS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void clear_timer(int idx);
    tmr_active[idx]    = 1'b0;
    tmr_periodic[idx]  = 1'b0;
    tmr_period[idx]    = '0;
    tmr_remaining[idx] = '0;
  endfunction

  function automatic void predict_timer_replies(mst_pkg::req_t req, logic [2:0] slot,
                                                logic [mst_pkg::PER_W-1:0] period,
                                                logic periodic);
    timer_reply_t batch[$];
    int free_idx;
    free_idx = -1;
    case (req)
      mst_pkg::REQ_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tmr_active[i] && tmr_remaining[i] != $signed(mst_pkg::REM_MIN))
            tmr_remaining[i] = tmr_remaining[i] - 16'sd1;
        end
      end
      mst_pkg::REQ_START: begin
        if (period == '0) begin
          batch.push_back('{mst_pkg::KIND_START, mst_pkg::STAT_ZERO_PERIOD, 3'd0, 1'b1});
        end else begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!tmr_active[i]) free_idx = i;
          end
          if (free_idx < 0) begin
            batch.push_back('{mst_pkg::KIND_START, mst_pkg::STAT_FULL, 3'd0, 1'b1});
          end else begin
            tmr_active[free_idx]    = 1'b1;
            tmr_periodic[free_idx]  = periodic;
            tmr_period[free_idx]    = period;
            tmr_remaining[free_idx] = $signed({1'b0, period});
            batch.push_back('{mst_pkg::KIND_START, mst_pkg::STAT_OK, 3'(free_idx), 1'b1});
          end
        end
      end
      mst_pkg::REQ_STOP: begin
        if (slot < SLOTS) clear_timer(slot);
        batch.push_back('{mst_pkg::KIND_STOP, mst_pkg::STAT_OK, slot, 1'b1});
      end
      default: begin
        for (int i = 0; i < SLOTS && batch.size() < mst_pkg::MAX_RESULTS; i++) begin
          if (tmr_active[i] && tmr_remaining[i] <= 0) begin
            batch.push_back('{mst_pkg::KIND_EXPIRY, mst_pkg::STAT_OK, 3'(i), 1'b0});
            if (tmr_periodic[i])
              tmr_remaining[i] = tmr_remaining[i] + $signed({1'b0, tmr_period[i]});
            else
              clear_timer(i);
          end
        end
        if (batch.size() == 0)
          batch.push_back('{mst_pkg::KIND_NONE, mst_pkg::STAT_OK, 3'd0, 1'b1});
        else
          batch[batch.size() - 1].last = 1'b1;
      end
    endcase
    foreach (batch[k]) expected_replies.push_back(batch[k]);
  endfunction

  task automatic send_word(input mst_pkg::req_t req, input logic [2:0] slot,
                           input logic [mst_pkg::PER_W-1:0] period,
                           input logic periodic);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!gapless && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {5'd0, periodic, period, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (req == mst_pkg::REQ_TICK) ticks_sent++;
    predict_timer_replies(req, slot, period, periodic);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = 500;
      hold_request = 1'b0;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(5, 60);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    timer_reply_t got;
    timer_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{mst_pkg::kind_t'(m_tuser), mst_pkg::status_t'(m_tdata[1:0]),
              m_tdata[4:2], m_tlast};
      replies_checked++;
      if (got.kind == mst_pkg::KIND_EXPIRY) expiries_seen++;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply kind=%0d status=%0d slot=%0d last=%0d",
                 $time, got.kind, got.status, got.slot, got.last);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.slot !== want.slot || got.last !== want.last) begin
          $display("%0t: mismatch expected kind=%0d status=%0d slot=%0d last=%0d",
                   $time, want.kind, want.status, want.slot, want.last);
          $display("%0t:          actual   kind=%0d status=%0d slot=%0d last=%0d",
                   $time, got.kind, got.status, got.slot, got.last);
          error_count++;
        end
      end
    end
  end

  task automatic test_start_limits();
    send_word(mst_pkg::REQ_START, 3'd5, 15'd0, 1'b1);
    send_word(mst_pkg::REQ_START, 3'd0, 15'd1, 1'b0);
    send_word(mst_pkg::REQ_START, 3'd7, 15'h7FFF, 1'b1);
    send_word(mst_pkg::REQ_START, 3'd2, 15'h5555, 1'b1);
    send_word(mst_pkg::REQ_START, 3'd5, 15'h2AAA, 1'b0);
    for (int i = 0; i < SLOTS - 4; i++) send_word(mst_pkg::REQ_START, 3'(i), 15'd40, 1'(i));
    send_word(mst_pkg::REQ_START, 3'd1, 15'd5, 1'b1);
    send_word(mst_pkg::REQ_START, 3'd1, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_TICK, 3'd7, 15'h7FFF, 1'b1);
    send_word(mst_pkg::REQ_DISPATCH, 3'd7, 15'h7FFF, 1'b1);
    send_word(mst_pkg::REQ_DISPATCH, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_START, 3'd0, 15'd3, 1'b1);
    drain();
  endtask

  task automatic test_stop_cases();
    send_word(mst_pkg::REQ_STOP, 3'd7, 15'h7FFF, 1'b1);
    send_word(mst_pkg::REQ_STOP, 3'd7, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_STOP, 3'd3, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_START, 3'd0, 15'd9, 1'b0);
    drain();
  endtask

  task automatic test_full_dispatch();
    for (int i = 0; i < SLOTS; i++) send_word(mst_pkg::REQ_STOP, 3'(i), 15'd0, 1'b0);
    for (int i = 0; i < SLOTS; i++) send_word(mst_pkg::REQ_START, 3'd0, 15'd1, 1'(i));
    send_word(mst_pkg::REQ_TICK, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_DISPATCH, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_DISPATCH, 3'd0, 15'd0, 1'b0);
    drain();
  endtask

  task automatic test_tick_overshoot();
    for (int i = 0; i < SLOTS; i++) send_word(mst_pkg::REQ_STOP, 3'(i), 15'd0, 1'b0);
    send_word(mst_pkg::REQ_START, 3'd0, 15'd1, 1'b1);
    send_word(mst_pkg::REQ_START, 3'd0, 15'd2, 1'b0);
    gapless = 1'b1;
    for (int i = 0; i < OVERSHOOT_TICKS; i++) begin
      send_word(mst_pkg::REQ_TICK, 3'(i), 15'(i), 1'(i));
    end
    gapless = 1'b0;
    send_word(mst_pkg::REQ_DISPATCH, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_DISPATCH, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_STOP, 3'd0, 15'd0, 1'b0);
    drain();
  endtask

  task automatic test_output_hold();
    @(posedge clk);
    hold_request = 1'b1;
    send_word(mst_pkg::REQ_START, 3'd0, 15'd1, 1'b0);
    send_word(mst_pkg::REQ_START, 3'd0, 15'd1, 1'b1);
    send_word(mst_pkg::REQ_TICK, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_DISPATCH, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_STOP, 3'd1, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_START, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_START, 3'd0, 15'd2, 1'b1);
    send_word(mst_pkg::REQ_DISPATCH, 3'd0, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_STOP, 3'd6, 15'd0, 1'b0);
    send_word(mst_pkg::REQ_DISPATCH, 3'd0, 15'd0, 1'b0);
    drain();
  endtask

  task automatic test_random_traffic();
    int            pick;
    int            pscale;
    mst_pkg::req_t req;
    logic [14:0]   period;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick   = $urandom_range(0, 99);
      pscale = $urandom_range(0, 19);
      if (pick < 35)      req = mst_pkg::REQ_TICK;
      else if (pick < 62) req = mst_pkg::REQ_START;
      else if (pick < 77) req = mst_pkg::REQ_STOP;
      else                req = mst_pkg::REQ_DISPATCH;
      if (pscale == 0)      period = '0;
      else if (pscale < 3)  period = 15'($urandom_range(1, 32767));
      else                  period = 15'($urandom_range(1, 10));
      send_word(req, 3'($urandom_range(0, 7)), period, 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = mst_pkg::REQ_TICK;
    m_tready     = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    words_sent   = 0;
    ticks_sent   = 0;
    replies_checked = 0;
    expiries_seen   = 0;
    burst_left   = 0;
    gapless      = 1'b0;
    hold_request = 1'b0;
    hold_left    = 0;
    stall_mode   = 0;
    mode_left    = 0;
    for (int i = 0; i < SLOTS; i++) clear_timer(i);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_start_limits();
    test_stop_cases();
    test_full_dispatch();
    test_tick_overshoot();
    test_output_hold();
    test_random_traffic();

    $display("Sent %0d request words, %0d of them ticks, including a long overshoot run.",
             words_sent, ticks_sent);
    $display("Checked %0d replies, %0d of them expiries, under output stalls and one long hold.",
             replies_checked, expiries_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
